### rtl/btp_pkg.sv
// shared types, constants and helper functions for the branch trace profiler
`timescale 1ns / 1ps
`default_nettype none

package btp_pkg;

  localparam int COUNT_BITS  = 48;
  localparam int PC_BITS     = 64;
  localparam int WIN_BITS    = 32;
  localparam int NUM_BINS    = 64;
  localparam int BIN_BITS    = $clog2(NUM_BINS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [WIN_BITS-1:0] RESET_WINDOW = WIN_BITS'(1000000);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PC_BITS-1:0]    pc_t;
  typedef logic [WIN_BITS-1:0]   win_t;
  typedef logic [BIN_BITS-1:0]   bin_t;

  // classified word passed from front to back
  typedef struct packed {
    logic   jump_valid;
    bin_t   jump_bucket;
    logic   window_end;
    win_t   window_number;
    win_t   window_branch_count;
    win_t   window_taken_count;
    count_t total_branch_count;
    count_t total_taken_count;
    count_t backward_count;
  } btp_word_t;

  // finished result word
  typedef struct packed {
    logic   jump_valid;
    bin_t   jump_bucket;
    count_t bucket_count;
    logic   window_end;
    win_t   window_number;
    win_t   window_branch_count;
    win_t   window_taken_count;
    count_t total_branch_count;
    count_t total_taken_count;
    count_t backward_count;
  } btp_result_t;

  // saturating increment at all ones
  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (&v) ? v : v + count_t'(1);
    return r;
  endfunction

  // floor log2, zero for inputs of zero or one
  function automatic bin_t floor_log2(input pc_t v);
    bin_t r;
    r = '0;
    for (int i = 1; i < PC_BITS; i++) begin
      if (v[i]) begin
        r = bin_t'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/btp_if.sv
// valid/ready channel interfaces for instruction and result words
`timescale 1ns / 1ps
`default_nettype none

interface btp_in_if;
  import btp_pkg::*;
  logic valid;
  logic ready;
  pc_t  pc;
  pc_t  next_pc;
  logic is_branch;
  logic was_taken;

  modport source (output valid, output pc, output next_pc, output is_branch,
                  output was_taken, input ready);
  modport sink (input valid, input pc, input next_pc, input is_branch,
                input was_taken, output ready);
endinterface

interface btp_out_if;
  import btp_pkg::*;
  logic   valid;
  logic   ready;
  logic   jump_valid;
  bin_t   jump_bucket;
  count_t bucket_count;
  logic   window_end;
  win_t   window_number;
  win_t   window_branch_count;
  win_t   window_taken_count;
  count_t total_branch_count;
  count_t total_taken_count;
  count_t backward_count;

  modport source (output valid, output jump_valid, output jump_bucket,
                  output bucket_count, output window_end, output window_number,
                  output window_branch_count, output window_taken_count,
                  output total_branch_count, output total_taken_count,
                  output backward_count, input ready);
  modport sink (input valid, input jump_valid, input jump_bucket,
                input bucket_count, input window_end, input window_number,
                input window_branch_count, input window_taken_count,
                input total_branch_count, input total_taken_count,
                input backward_count, output ready);
endinterface

`default_nettype wire

### rtl/btp_front.sv
// front end: jump bucket, window tracking and running totals per instruction
`timescale 1ns / 1ps
`default_nettype none

module btp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire btp_pkg::win_t      cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire btp_pkg::pc_t       in_pc,
  input  wire btp_pkg::pc_t       in_next_pc,
  input  wire logic               in_is_branch,
  input  wire logic               in_was_taken,
  output      logic               push,
  output      btp_pkg::btp_word_t push_word,
  input  wire logic               queue_ready
);
  import btp_pkg::*;

  win_t   win_len_r;
  pc_t    prev_pc_r;
  logic   have_prev_r;
  win_t   win_inst_r,  win_inst_nxt;
  win_t   win_br_r,    win_br_nxt;
  win_t   win_tk_r,    win_tk_nxt;
  win_t   win_idx_r,   win_idx_nxt;
  count_t br_tot_r,    br_tot_nxt;
  count_t tk_tot_r,    tk_tot_nxt;
  count_t bw_tot_r,    bw_tot_nxt;

  pc_t    pc_gap;
  logic   taken;
  logic   backward;
  logic   wend;
  win_t   inst_inc;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  // classify the incoming word
  always_comb begin
    pc_gap   = (in_pc >= prev_pc_r) ? in_pc - prev_pc_r : prev_pc_r - in_pc;
    taken    = in_is_branch && in_was_taken;
    backward = taken && (in_next_pc < in_pc);
    inst_inc = win_inst_r + win_t'(1);
    wend     = (inst_inc >= win_len_r);

    win_br_nxt  = win_br_r + win_t'(in_is_branch);
    win_tk_nxt  = win_tk_r + win_t'(taken);
    br_tot_nxt  = in_is_branch ? sat_inc(br_tot_r) : br_tot_r;
    tk_tot_nxt  = taken ? sat_inc(tk_tot_r) : tk_tot_r;
    bw_tot_nxt  = backward ? sat_inc(bw_tot_r) : bw_tot_r;
    win_inst_nxt = wend ? '0 : inst_inc;
    win_idx_nxt  = wend ? win_idx_r + win_t'(1) : win_idx_r;

    push_word.jump_valid          = have_prev_r;
    push_word.jump_bucket         = have_prev_r ? floor_log2(pc_gap) : '0;
    push_word.window_end          = wend;
    push_word.window_number       = wend ? win_idx_r : '0;
    push_word.window_branch_count = wend ? win_br_nxt : '0;
    push_word.window_taken_count  = wend ? win_tk_nxt : '0;
    push_word.total_branch_count  = br_tot_nxt;
    push_word.total_taken_count   = tk_tot_nxt;
    push_word.backward_count      = bw_tot_nxt;
  end

  // state update on accept, window length on config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r     <= RESET_WINDOW;
      prev_pc_r     <= '0;
      have_prev_r   <= 1'b0;
      win_inst_r    <= '0;
      win_br_r      <= '0;
      win_tk_r      <= '0;
      win_idx_r     <= '0;
      br_tot_r      <= '0;
      tk_tot_r      <= '0;
      bw_tot_r      <= '0;
    end else begin
      if (cfg_we) begin
        win_len_r <= cfg_wdata;
      end
      if (push) begin
        prev_pc_r   <= in_pc;
        have_prev_r <= 1'b1;
        win_inst_r  <= win_inst_nxt;
        win_br_r    <= wend ? '0 : win_br_nxt;
        win_tk_r    <= wend ? '0 : win_tk_nxt;
        win_idx_r   <= win_idx_nxt;
        br_tot_r    <= br_tot_nxt;
        tk_tot_r    <= tk_tot_nxt;
        bw_tot_r    <= bw_tot_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/btp_queue.sv
// short word queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module btp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire btp_pkg::btp_word_t push_word,
  output      logic               ready,
  output      logic               head_valid,
  output      btp_pkg::btp_word_t head_word,
  input  wire logic               pop
);
  import btp_pkg::*;

  btp_word_t                slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]     wr_ptr_r;
  logic [QPTR_BITS-1:0]     rd_ptr_r;
  logic [QPTR_BITS:0]       fill_r, fill_nxt;

  assign ready      = (fill_r != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_word  = slot_r[rd_ptr_r];

  // fill level
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_BITS+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_BITS+1)'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

### rtl/btp_back.sv
// back end: histogram read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none

module btp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 head_valid,
  input  wire btp_pkg::btp_word_t   head_word,
  output      logic                 pop,
  output      logic                 out_valid,
  output      btp_pkg::btp_result_t out_word,
  input  wire logic                 out_ready
);
  import btp_pkg::*;

  // histogram memory and per-bin valid bits
  count_t              hist_mem [NUM_BINS];
  logic [NUM_BINS-1:0] hist_vld_r;

  // read stage
  logic      rd_valid_r;
  btp_word_t rd_word_r;
  count_t    rd_data_r;
  logic      rd_bin_vld_r;
  logic      hit_r;
  count_t    hit_cnt_r;

  // result register
  logic        o_valid_r;
  btp_result_t o_word_r;

  logic   o_free;
  logic   rd_fire;
  logic   wr_en;
  logic   hit_nxt;
  count_t base_cnt;
  count_t new_cnt;

  assign o_free    = out_ready || !o_valid_r;
  assign rd_fire   = rd_valid_r && o_free;
  assign pop       = head_valid && (!rd_valid_r || rd_fire);
  assign wr_en     = rd_fire && rd_word_r.jump_valid;
  assign out_valid = o_valid_r;
  assign out_word  = o_word_r;

  // new bin count, forwarding a write that landed with the read
  always_comb begin
    if (hit_r) begin
      base_cnt = hit_cnt_r;
    end else if (rd_bin_vld_r) begin
      base_cnt = rd_data_r;
    end else begin
      base_cnt = '0;
    end
    new_cnt = sat_inc(base_cnt);
    hit_nxt = wr_en && (rd_word_r.jump_bucket == head_word.jump_bucket);
  end

  // histogram memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[rd_word_r.jump_bucket] <= new_cnt;
    end
    if (pop) begin
      rd_data_r <= hist_mem[head_word.jump_bucket];
    end
  end

  // valid bits and stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      rd_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        hist_vld_r[rd_word_r.jump_bucket] <= 1'b1;
      end
      if (pop) begin
        rd_valid_r <= 1'b1;
      end else if (rd_fire) begin
        rd_valid_r <= 1'b0;
      end
      if (rd_fire) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // payload of read stage and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_word_r    <= head_word;
      rd_bin_vld_r <= hist_vld_r[head_word.jump_bucket];
      hit_r        <= hit_nxt;
      hit_cnt_r    <= new_cnt;
    end
    if (rd_fire) begin
      o_word_r.jump_valid          <= rd_word_r.jump_valid;
      o_word_r.jump_bucket         <= rd_word_r.jump_bucket;
      o_word_r.bucket_count        <= rd_word_r.jump_valid ? new_cnt : '0;
      o_word_r.window_end          <= rd_word_r.window_end;
      o_word_r.window_number       <= rd_word_r.window_number;
      o_word_r.window_branch_count <= rd_word_r.window_branch_count;
      o_word_r.window_taken_count  <= rd_word_r.window_taken_count;
      o_word_r.total_branch_count  <= rd_word_r.total_branch_count;
      o_word_r.total_taken_count   <= rd_word_r.total_taken_count;
      o_word_r.backward_count      <= rd_word_r.backward_count;
    end
  end

endmodule

`default_nettype wire

### rtl/branch_trace_profiler.sv
// top level of the branch trace profiler
// Usage:
//   in_ch carries one retired instruction per word (pc, next_pc, is_branch,
//   was_taken); out_ch returns exactly one result word per instruction, in
//   order. Both channels are valid/ready, a word moves when both are high.
//   cfg_we/cfg_wdata write the window length; write it only while idle.
//   An accepted word passes the queue, read stage and result register.
//   Throughput: one word per cycle; the front end (jump distance, log2
//   bucket, window and total counters) and the back end (64-bin histogram
//   read-modify-write through a one-read one-write memory with forwarding)
//   each take a word every cycle and meet through a four-word queue.
//   Reset (rst_n low at a clock edge) clears all counters, sets the window
//   length to 1000000 and clears the histogram at once through per-bin valid
//   bits; no clearing pass follows, and words are taken on the next cycle.
//   When the receiver holds out_ch.ready low, the result register, the read
//   stage and the queue fill up in turn, after which in_ch.ready drops;
//   nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module branch_trace_profiler (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire btp_pkg::win_t cfg_wdata,
  btp_in_if.sink             in_ch,
  btp_out_if.source          out_ch
);
  import btp_pkg::*;

  logic        push;
  btp_word_t   push_word;
  logic        queue_ready;
  logic        head_valid;
  btp_word_t   head_word;
  logic        pop;
  logic        res_valid;
  btp_result_t res_word;

  // front end
  btp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_pc        (in_ch.pc),
    .in_next_pc   (in_ch.next_pc),
    .in_is_branch (in_ch.is_branch),
    .in_was_taken (in_ch.was_taken),
    .push         (push),
    .push_word    (push_word),
    .queue_ready  (queue_ready)
  );

  // decoupling queue
  btp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .ready      (queue_ready),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop)
  );

  // back end
  btp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_valid  (res_valid),
    .out_word   (res_word),
    .out_ready  (out_ch.ready)
  );

  // result channel
  assign out_ch.valid               = res_valid;
  assign out_ch.jump_valid          = res_word.jump_valid;
  assign out_ch.jump_bucket         = res_word.jump_bucket;
  assign out_ch.bucket_count        = res_word.bucket_count;
  assign out_ch.window_end          = res_word.window_end;
  assign out_ch.window_number       = res_word.window_number;
  assign out_ch.window_branch_count = res_word.window_branch_count;
  assign out_ch.window_taken_count  = res_word.window_taken_count;
  assign out_ch.total_branch_count  = res_word.total_branch_count;
  assign out_ch.total_taken_count   = res_word.total_taken_count;
  assign out_ch.backward_count      = res_word.backward_count;

endmodule

`default_nettype wire

### tb/tb_branch_trace_profiler.sv
// self-checking testbench for the branch trace profiler
`timescale 1ns / 1ps
`default_nettype none

module tb_branch_trace_profiler;
  import btp_pkg::*;

  // one retired instruction as the sender sees it
  typedef struct {
    pc_t  pc;
    pc_t  next_pc;
    logic is_branch;
    logic was_taken;
  } retired_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  win_t cfg_wdata;

  btp_in_if  in_ch ();
  btp_out_if out_ch ();

  branch_trace_profiler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  retired_t    retire_q[$];
  btp_result_t profile_q[$];
  int          n_issued   = 0;
  int          n_accepted = 0;
  int          n_checked  = 0;
  int          err_count  = 0;
  logic        in_went    = 1'b0;
  int          hold_left  = 0;
  logic        held_once  = 1'b0;
  pc_t         gen_pc     = '0;

  // shadow of the profiler state
  win_t   win_size;
  pc_t    last_pc;
  logic   seen_pc;
  count_t hist[NUM_BINS];
  win_t   win_insts;
  win_t   win_branches;
  win_t   win_taken;
  win_t   win_idx;
  count_t br_total;
  count_t tk_total;
  count_t back_total;

  function automatic count_t bump(input count_t v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
  endfunction

  // highest set bit, distances 0 and 1 land in bin 0
  function automatic bin_t distance_bin(input pc_t d);
    bin_t b;
    b = '0;
    for (int i = PC_BITS - 1; i > 0; i--) begin
      if (d[i] && b == '0) begin
        b = bin_t'(i);
      end
    end
    return b;
  endfunction

  function automatic void clear_profile();
    win_size     = RESET_WINDOW;
    last_pc      = '0;
    seen_pc      = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      hist[i] = '0;
    end
    win_insts    = '0;
    win_branches = '0;
    win_taken    = '0;
    win_idx      = '0;
    br_total     = '0;
    tk_total     = '0;
    back_total   = '0;
  endfunction

  // advance the shadow state by one instruction and build its result word
  function automatic btp_result_t profile_step(input retired_t it);
    btp_result_t r;
    pc_t         pc_gap;
    bin_t        b;
    r = '0;
    win_insts = win_insts + win_t'(1);
    if (seen_pc) begin
      pc_gap = (it.pc > last_pc) ? it.pc - last_pc : last_pc - it.pc;
      b = distance_bin(pc_gap);
      hist[b] = bump(hist[b]);
      r.jump_valid   = 1'b1;
      r.jump_bucket  = b;
      r.bucket_count = hist[b];
    end
    last_pc = it.pc;
    seen_pc = 1'b1;
    if (it.is_branch) begin
      br_total     = bump(br_total);
      win_branches = win_branches + win_t'(1);
      if (it.was_taken) begin
        tk_total  = bump(tk_total);
        win_taken = win_taken + win_t'(1);
        if (it.next_pc < it.pc) begin
          back_total = bump(back_total);
        end
      end
    end
    if (win_insts >= win_size) begin
      r.window_end          = 1'b1;
      r.window_number       = win_idx;
      r.window_branch_count = win_branches;
      r.window_taken_count  = win_taken;
      win_idx      = win_idx + win_t'(1);
      win_insts    = '0;
      win_branches = '0;
      win_taken    = '0;
    end
    r.total_branch_count = br_total;
    r.total_taken_count  = tk_total;
    r.backward_count     = back_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at word %0d: %s got %h want %h", n_checked, what, got, want);
    err_count++;
  endtask

  task automatic check_word(input btp_result_t got, input btp_result_t want);
    if (got.jump_valid !== want.jump_valid)
      report_mismatch("jump_valid", 64'(got.jump_valid), 64'(want.jump_valid));
    if (got.jump_bucket !== want.jump_bucket)
      report_mismatch("jump_bucket", 64'(got.jump_bucket), 64'(want.jump_bucket));
    if (got.bucket_count !== want.bucket_count)
      report_mismatch("bucket_count", 64'(got.bucket_count), 64'(want.bucket_count));
    if (got.window_end !== want.window_end)
      report_mismatch("window_end", 64'(got.window_end), 64'(want.window_end));
    if (got.window_number !== want.window_number)
      report_mismatch("window_number", 64'(got.window_number),
                      64'(want.window_number));
    if (got.window_branch_count !== want.window_branch_count)
      report_mismatch("window_branch_count", 64'(got.window_branch_count),
                      64'(want.window_branch_count));
    if (got.window_taken_count !== want.window_taken_count)
      report_mismatch("window_taken_count", 64'(got.window_taken_count),
                      64'(want.window_taken_count));
    if (got.total_branch_count !== want.total_branch_count)
      report_mismatch("total_branch_count", 64'(got.total_branch_count),
                      64'(want.total_branch_count));
    if (got.total_taken_count !== want.total_taken_count)
      report_mismatch("total_taken_count", 64'(got.total_taken_count),
                      64'(want.total_taken_count));
    if (got.backward_count !== want.backward_count)
      report_mismatch("backward_count", 64'(got.backward_count),
                      64'(want.backward_count));
  endtask

  // sample both handshakes and the register write at the rising edge
  always @(posedge clk) begin
    btp_result_t got;
    btp_result_t want;
    retired_t    it;
    if (!rst_n) begin
      clear_profile();
      in_went <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_size = cfg_wdata;
      end
      in_went <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        it.pc        = in_ch.pc;
        it.next_pc   = in_ch.next_pc;
        it.is_branch = in_ch.is_branch;
        it.was_taken = in_ch.was_taken;
        want = profile_step(it);
        profile_q = {profile_q, want};
        n_accepted <= n_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.jump_valid          = out_ch.jump_valid;
        got.jump_bucket         = out_ch.jump_bucket;
        got.bucket_count        = out_ch.bucket_count;
        got.window_end          = out_ch.window_end;
        got.window_number       = out_ch.window_number;
        got.window_branch_count = out_ch.window_branch_count;
        got.window_taken_count  = out_ch.window_taken_count;
        got.total_branch_count  = out_ch.total_branch_count;
        got.total_taken_count   = out_ch.total_taken_count;
        got.backward_count      = out_ch.backward_count;
        if (profile_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(got.jump_bucket), '0);
        end else begin
          check_word(got, profile_q.pop_front());
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  // instruction driver, calm stretch while words 110 to 169 go in
  always @(negedge clk) begin
    retired_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_went) begin
      if (retire_q.size() != 0 &&
          ((n_accepted >= 110 && n_accepted < 170) || $urandom_range(99) >= 16)) begin
        it = retire_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.pc        <= it.pc;
        in_ch.next_pc   <= it.next_pc;
        in_ch.is_branch <= it.is_branch;
        in_ch.was_taken <= it.was_taken;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!held_once && n_checked >= 320) begin
      held_once    <= 1'b1;
      hold_left    <= 80;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (n_checked >= 110 && n_checked < 170) || $urandom_range(99) >= 16;
    end
  end

  task automatic issue(input pc_t pc, input pc_t npc, input logic br, input logic tk);
    retired_t it;
    it.pc        = pc;
    it.next_pc   = npc;
    it.is_branch = br;
    it.was_taken = tk;
    retire_q = {retire_q, it};
    gen_pc = pc;
    n_issued++;
  endtask

  // mostly nearby jumps of random log2 size, some fully random addresses
  task automatic issue_random(input int count);
    pc_t step;
    pc_t pc;
    pc_t npc;
    for (int n = 0; n < count; n++) begin
      step = {$urandom, $urandom} >> (63 - $urandom_range(63));
      case ($urandom_range(7))
        0:       pc = {$urandom, $urandom};
        1, 2, 3: pc = gen_pc + step;
        4, 5:    pc = gen_pc - step;
        default: pc = gen_pc + 64'd4;
      endcase
      step = {$urandom, $urandom} >> (63 - $urandom_range(63));
      case ($urandom_range(3))
        0:       npc = pc + 64'd4;
        1:       npc = pc - step;
        2:       npc = pc + step;
        default: npc = {$urandom, $urandom};
      endcase
      issue(pc, npc, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // wait until every issued word has come back
  task automatic drain();
    while (n_accepted != n_issued || n_checked != n_accepted) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input win_t size);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.pc         = '0;
    in_ch.next_pc    = '0;
    in_ch.is_branch  = 1'b0;
    in_ch.was_taken  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset window size
    issue(64'h1000, 64'h1004, 1'b0, 1'b0);            // no previous pc yet
    issue(64'h1000, 64'h1004, 1'b1, 1'b0);            // distance zero
    issue(64'h1001, 64'h2000, 1'b1, 1'b1);            // distance one, forward taken
    issue(64'h1003, 64'h0, 1'b1, 1'b1);               // backward taken
    issue(64'h1000, 64'h0, 1'b0, 1'b1);               // taken flag without branch
    issue(64'h0, {64{1'b1}}, 1'b1, 1'b1);
    issue({64{1'b1}}, 64'h0, 1'b1, 1'b1);             // largest distance
    issue(64'h0, 64'h0, 1'b1, 1'b1);
    issue(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
    issue(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    issue(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b1);
    issue(64'hAAAA_AAAA_AAAA_AAAB, 64'hAAAA_AAAA_AAAA_AAAF, 1'b0, 1'b0);
    issue(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    issue(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0004, 1'b0, 1'b1);
    drain();

    write_window(32'd3);
    issue_random(80);
    drain();

    // shrink the window below the count already reached
    write_window(32'd10);
    issue_random(7);
    drain();
    write_window(32'd2);
    issue_random(3);
    drain();

    write_window(32'd1);
    issue_random(60);
    drain();

    // size zero closes a window on every word
    write_window(32'd0);
    issue_random(30);
    drain();

    write_window(32'hFFFF_FFFF);
    issue_random(80);
    drain();

    write_window(32'd5);
    issue_random(150);
    drain();

    if (profile_q.size() != 0) begin
      report_mismatch("words never returned", 64'(profile_q.size()), '0);
    end
    if (err_count == 0) begin
      $display("tb_branch_trace_profiler: clean");
    end else begin
      $display("tb_branch_trace_profiler: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_branch_trace_profiler: errors");
    $finish;
  end

endmodule

`default_nettype wire
